[hdl/murmur2_string_hash_top_assert.svh]
// Assertion macros shared by the hash block.
`ifndef MURMUR2_STRING_HASH_TOP_ASSERT_SVH
`define MURMUR2_STRING_HASH_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MH2_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mh2 implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MH2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mh2 next-cycle check failed");

`endif

[hdl/mh2_pkg.sv]
// Types and constants of the MurmurHash2 string hash block.
`default_nettype none
package mh2_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam logic [31:0] SEED_RESET = 32'h3FB0BB5F;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam int unsigned AVAL_SH1   = 13;
  localparam int unsigned AVAL_SH2   = 15;

  // One command from the front end to the mixing engine.
  typedef struct packed {
    logic        start;    // reload running hash with init
    logic [31:0] init;     // seed ^ length
    logic        has_word; // word is a full little-endian word to mix
    logic [31:0] word;
    logic        is_end;   // finish the string and emit a hash
    logic        tail_nz;  // tail bytes pending
    logic [23:0] tail;
  } mh2_cmd_t;

  // Command queue status.
  typedef struct packed {
    logic empty;
    logic full;
  } mh2_qstat_t;

endpackage
`default_nettype wire

[hdl/mh2_front.sv]
// Front end: byte gathering and command generation.
`default_nettype none
module mh2_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [31:0]      seed,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       data_byte,
  input  wire logic             byte_valid,
  input  wire logic             start_of_string,
  input  wire logic             end_of_string,
  input  wire logic [31:0]      string_length,
  input  wire mh2_pkg::mh2_qstat_t qstat,
  output logic                  push,
  output mh2_pkg::mh2_cmd_t     push_cmd
);
  import mh2_pkg::*;

  logic [23:0] bytes_r, bytes_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [23:0] bytes0, bytes1;
  logic [1:0]  cnt0, cnt1;
  logic        has_word;
  logic        accept;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cnt0     = start_of_string ? 2'd0 : cnt_r;
    bytes0   = start_of_string ? 24'd0 : bytes_r;
    cnt1     = cnt0;
    bytes1   = bytes0;
    has_word = 1'b0;
    if (byte_valid) begin
      unique case (cnt0)
        2'd0: begin
          bytes1[7:0] = data_byte;
          cnt1        = 2'd1;
        end
        2'd1: begin
          bytes1[15:8] = data_byte;
          cnt1         = 2'd2;
        end
        2'd2: begin
          bytes1[23:16] = data_byte;
          cnt1          = 2'd3;
        end
        2'd3: begin
          has_word = 1'b1;
          bytes1   = 24'd0;
          cnt1     = 2'd0;
        end
      endcase
    end
    cnt_nxt   = end_of_string ? 2'd0 : cnt1;
    bytes_nxt = end_of_string ? 24'd0 : bytes1;
  end

  always_comb begin
    push_cmd.start    = start_of_string;
    push_cmd.init     = seed ^ string_length;
    push_cmd.has_word = has_word;
    push_cmd.word     = {data_byte, bytes0};
    push_cmd.is_end   = end_of_string;
    push_cmd.tail_nz  = (cnt1 != 2'd0);
    push_cmd.tail     = bytes1;
  end

  // Items that only add a byte to the pending word need no command.
  assign push = accept && (start_of_string || has_word || end_of_string);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      bytes_r <= 24'd0;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      bytes_r <= bytes_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/mh2_cmdq.sv]
// Command queue between front end and mixing engine.
`default_nettype none
module mh2_cmdq #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mh2_pkg::mh2_cmd_t push_cmd,
  input  wire logic              pop,
  output mh2_pkg::mh2_cmd_t      head,
  output mh2_pkg::mh2_qstat_t    qstat
);
  import mh2_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mh2_cmd_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == CW'(DEPTH));
  assign head        = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/mh2_back.sv]
// Mixing engine: word mix, tail, avalanche on one shared multiplier.
`default_nettype none
module mh2_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mh2_pkg::mh2_cmd_t head,
  input  wire mh2_pkg::mh2_qstat_t qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            hash_value
);
  import mh2_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WK2, ST_WK3, ST_WK4, ST_ET, ST_EA, ST_EF
  } state_t;

  state_t      state_r;
  mh2_cmd_t    cmd_r;
  logic [31:0] h_r, k_r, prod_r, out_data_r;
  logic        out_valid_r;
  logic [31:0] mul_op, prod_nxt, result;
  logic        out_free;

  assign pop        = (state_r == ST_IDLE) && !qstat.empty;
  assign out_valid  = out_valid_r;
  assign hash_value = out_data_r;
  assign out_free   = !out_valid_r || out_ready;
  assign result     = prod_r ^ (prod_r >> AVAL_SH2);

  always_comb begin
    unique case (state_r)
      ST_IDLE: mul_op = head.word;
      ST_WK2:  mul_op = prod_r ^ (prod_r >> MIX_SHIFT);
      ST_ET:   mul_op = cmd_r.tail_nz ? (h_r ^ {8'd0, cmd_r.tail}) : (h_r ^ (h_r >> AVAL_SH1));
      ST_EA:   mul_op = prod_r ^ (prod_r >> AVAL_SH1);
      default: mul_op = h_r;
    endcase
  end

  // Low 32 bits of the product only.
  assign prod_nxt = mul_op * MIX_MUL;

  always_ff @(posedge clk) begin
    if (state_r != ST_EF) prod_r <= prod_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == ST_EF) && out_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            cmd_r <= head;
            if (head.start) h_r <= head.init;
            if (head.has_word)    state_r <= ST_WK2;
            else if (head.is_end) state_r <= ST_ET;
          end
        end
        ST_WK2: state_r <= ST_WK3;
        ST_WK3: begin
          k_r     <= prod_r;
          state_r <= ST_WK4;
        end
        ST_WK4: begin
          h_r     <= prod_r ^ k_r;
          state_r <= cmd_r.is_end ? ST_ET : ST_IDLE;
        end
        ST_ET: state_r <= cmd_r.tail_nz ? ST_EA : ST_EF;
        ST_EA: state_r <= ST_EF;
        ST_EF: begin
          if (out_free) begin
            out_data_r  <= result;
            h_r         <= 32'd0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/murmur2_string_hash_top.sv]
// Top level of the streaming MurmurHash2 string hash.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: data_byte, string_length
//          |     |                        | tuser: byte_valid, start_of_string
//          |     |                        | tlast: end_of_string
//  out_    | out | out_tvalid / out_tready| tdata: hash_value
//  cfg_    | in  | APB, pready tied high  | reg 0 at 0x0: seed
//
//  The front end takes one byte transaction per cycle while the command queue
//  has room. Only start, full-word and end items become commands.
//  The mixing engine makes three passes through its one 32x32 multiplier per
//  full word (the first in the pop cycle) and then folds k into h, so word
//  mixing keeps pace with one byte per cycle while no result waits at the
//  output; a start alone reloads h, an end adds tail and avalanche passes.
//  Reset is synchronous on rst_n and clears all control state; no clear pass.
//  A stalled result sits in the output register; the engine waits there while
//  the queue keeps taking input until it fills.
`default_nettype none
module murmur2_string_hash_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] data_byte, [39:8] string_length
  input  wire logic [39:0] in_tdata,
  // in_tuser: [0] byte_valid, [1] start_of_string
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: [31:0] hash_value
  output logic [31:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import mh2_pkg::*;

  localparam logic REG_SEED = 1'b0;

  logic [31:0] seed_r;
  logic        cfg_wr;
  mh2_qstat_t  qstat;
  mh2_cmd_t    push_cmd, head;
  logic        q_push, q_pop;

  // Config register; the user must write it only while the block is idle, the block does not enforce it.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_SEED)) begin
      seed_r <= cfg_pwdata;
    end
  end

  mh2_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .seed            (seed_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .data_byte       (in_tdata[7:0]),
    .byte_valid      (in_tuser[0]),
    .start_of_string (in_tuser[1]),
    .end_of_string   (in_tlast),
    .string_length   (in_tdata[39:8]),
    .qstat           (qstat),
    .push            (q_push),
    .push_cmd        (push_cmd)
  );

  mh2_cmdq #(.DEPTH(QUEUE_DEPTH)) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .qstat    (qstat)
  );

  mh2_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hash_value (out_tdata)
  );

  `include "murmur2_string_hash_top_assert.svh"

  // No push into a full queue, no pop from an empty one.
  `MH2_ASSERT_IMPL(a_no_overflow, q_push, !qstat.full)
  `MH2_ASSERT_IMPL(a_no_underflow, q_pop, !qstat.empty)
  // A push without a pop leaves something to pop.
  `MH2_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !qstat.empty)

endmodule
`default_nettype wire

[dv/murmur2_string_hash_top_tb.sv]
// Self-checking testbench for the streaming MurmurHash2 string hash block.
module murmur2_string_hash_top_tb;

  localparam logic [31:0] HASH_MUL      = 32'h5bd1e995;
  localparam logic [31:0] SEED_AT_RESET = 32'h3FB0BB5F;
  localparam logic [2:0]  SEED_ADDR     = 3'd0;      // seed register, byte address
  localparam logic        APB_WRITE     = 1'b1;
  localparam logic        APB_READ      = 1'b0;
  localparam int unsigned MAX_GAP       = 14;        // longest idle draw, either side
  localparam int unsigned PHASE_ITEMS   = 296;       // random transactions per seed setting
  localparam int unsigned LONG_HOLD     = 300;       // receiver hold-off that backs up the queue
  localparam int unsigned SETTLE_CYCLES = 24;        // engine work after the last hash

  // One input transaction, field by field.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        start_of_string;
    logic        end_of_string;
    logic [31:0] string_length;
  } str_item_t;

  // Predicts the hash of every string and checks the block's results in order.
  class murmur_scoreboard;
    logic [31:0] seed;
    logic [31:0] run_hash;
    logic [23:0] tail_bytes;
    logic [1:0]  tail_cnt;
    logic [31:0] expected_hashes[$];
    int unsigned errors;
    int unsigned hashes_checked;

    function new();
      seed           = SEED_AT_RESET;
      run_hash       = '0;
      tail_bytes     = '0;
      tail_cnt       = '0;
      errors         = 0;
      hashes_checked = 0;
    endfunction

    // Order inside one transaction: start, then byte, then end.
    function void note_input(str_item_t it);
      logic [31:0] word;
      logic [31:0] fin;
      if (it.start_of_string) begin
        run_hash   = seed ^ it.string_length;
        tail_bytes = '0;
        tail_cnt   = '0;
      end
      if (it.byte_valid) begin
        if (tail_cnt == 2'd3) begin
          // full little-endian word: k*M, k^=k>>24, k*M, then h = h*M ^ k
          word       = {it.data_byte, tail_bytes} * HASH_MUL;
          word       = word ^ (word >> 24);
          word       = word * HASH_MUL;
          run_hash   = (run_hash * HASH_MUL) ^ word;
          tail_bytes = '0;
          tail_cnt   = '0;
        end else begin
          tail_bytes = tail_bytes | (24'(it.data_byte) << (8 * tail_cnt));
          tail_cnt   = tail_cnt + 2'd1;
        end
      end
      if (it.end_of_string) begin
        fin = run_hash;
        if (tail_cnt != 2'd0)
          fin = (fin ^ {8'h00, tail_bytes}) * HASH_MUL;
        fin = fin ^ (fin >> 13);
        fin = fin * HASH_MUL;
        fin = fin ^ (fin >> 15);
        expected_hashes.push_back(fin);
        run_hash   = '0;
        tail_bytes = '0;
        tail_cnt   = '0;
      end
    endfunction

    function void check_hash(logic [31:0] got);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        $display("%0t: hash_value %h arrived with no string pending", $time, got);
        errors++;
      end else begin
        want = expected_hashes.pop_front();
        hashes_checked++;
        if (got !== want) begin
          $display("%0t: hash_value mismatch, expected %h, got %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function bit drained();
      return expected_hashes.size() == 0;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic [39:0] in_tdata;    // [7:0] data_byte, [39:8] string_length
  logic [1:0]  in_tuser;    // [0] byte_valid, [1] start_of_string
  logic        in_tlast;    // end_of_string
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;   // [31:0] hash_value
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  murmur_scoreboard scb;

  // Sender bookkeeping: offering mirrors in_tvalid as driven, so it is lowered
  // only once per time step and never lowered and raised in the same step.
  bit          offering   = 1'b0;
  bit          tx_burst   = 1'b0;   // random stretches with back-to-back transactions
  bit          tx_no_gap  = 1'b0;   // forced back-to-back while the receiver holds off
  int unsigned items_sent = 0;      // transactions the block acts on
  int unsigned rx_hold    = 0;      // pending long hold-off request for the receiver

  murmur2_string_hash_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs a handshake.
  initial begin : watchdog
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic str_item_t make_item(logic [7:0] b, logic v, logic s, logic e,
                                          logic [31:0] len);
    str_item_t it;
    it.data_byte       = b;
    it.byte_valid      = v;
    it.start_of_string = s;
    it.end_of_string   = e;
    it.string_length   = len;
    return it;
  endfunction

  task automatic stop_input();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offers one transaction after a random idle gap and returns at the edge that
  // accepts it; tvalid stays up when the next one follows without a gap.
  task automatic send_item(str_item_t it);
    int unsigned gap;
    gap = (tx_no_gap || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0)
      tx_burst = !tx_burst;
    if (gap > 0) begin
      stop_input();
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {it.string_length, it.data_byte};
    in_tuser  <= {it.start_of_string, it.byte_valid};
    in_tlast  <= it.end_of_string;
    in_tvalid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    scb.note_input(it);
    if (it.byte_valid || it.start_of_string || it.end_of_string)
      items_sent++;
  endtask

  // A well-formed string of n bytes. Start and end marks ride on the first and
  // last bytes or on byte-less transactions of their own; the length field
  // sometimes disagrees with n, and ignored fillers may fall in between.
  task automatic send_string(int unsigned n);
    logic [31:0] len;
    logic        split_start;
    logic        split_end;
    int unsigned i;
    len         = ($urandom_range(0, 7) == 0) ? $urandom() : n;
    split_start = (n == 0) || ($urandom_range(0, 5) == 0);
    split_end   = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
    if (split_start)
      send_item(make_item(8'($urandom()), 1'b0, 1'b1, (n == 0) && !split_end, len));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(make_item(8'($urandom()), 1'b0, 1'b0, 1'b0, $urandom()));
      send_item(make_item(8'($urandom()), 1'b1, (i == 0) && !split_start,
                          (i == n - 1) && !split_end, (i == 0) ? len : $urandom()));
    end
    if (split_end)
      send_item(make_item(8'($urandom()), 1'b0, 1'b0, 1'b1, $urandom()));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (!scb.drained());
  endtask

  // Block goes idle: all hashes in, then the engine gets time to finish
  // anything that produces no result.
  task automatic close_phase();
    stop_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_seed_reg(logic [31:0] want);
    logic [31:0] rd;
    cfg_access(APB_READ, SEED_ADDR, 32'h0, rd);
    if (rd !== want) begin
      $display("%0t: seed readback mismatch, expected %h, got %h", $time, want, rd);
      scb.errors++;
    end
  endtask

  // Mostly well-formed strings, short ones favored, some long enough for
  // many words; about one draw in ten is a single random noise transaction.
  task automatic run_random(int unsigned quota);
    int unsigned first_count;
    int unsigned r;
    int unsigned n;
    first_count = items_sent;
    while (items_sent - first_count < quota) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(make_item(8'($urandom()), 1'($urandom()), 1'($urandom()),
                            1'($urandom()), $urandom()));
      end else begin
        r = $urandom_range(0, 99);
        n = (r < 70) ? $urandom_range(0, 8) :
            (r < 95) ? $urandom_range(9, 24) : $urandom_range(25, 64);
        send_string(n);
      end
      // occasional full drain with the input idle
      if ($urandom_range(0, 149) == 0) begin
        stop_input();
        wait_drained();
      end
    end
    // close whatever the noise left half-finished
    send_item(make_item(8'($urandom()), 1'b0, 1'b0, 1'b1, $urandom()));
  endtask

  // Result side: random stall per transaction, runs of zero stall, and one
  // long hold-off on request to back the block up into its input.
  initial begin : hash_sink
    int unsigned stall;
    bit          rx_burst;
    bit          ready_q;
    rx_burst = 1'b0;
    ready_q  = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if ($urandom_range(0, 39) == 0)
        rx_burst = !rx_burst;
      if (stall > 0) begin
        if (ready_q)
          out_tready <= 1'b0;
        ready_q = 1'b0;
        repeat (stall) @(posedge clk);
      end
      if (!ready_q)
        out_tready <= 1'b1;
      ready_q = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      scb.check_hash(out_tdata);
    end
  end

  initial begin : stimulus
    logic [31:0] seed_plan [5];
    logic [31:0] rd;
    int unsigned p;
    int unsigned i;
    scb = new();
    seed_plan[0] = 32'h0000_0000;
    seed_plan[1] = 32'hFFFF_FFFF;
    seed_plan[2] = $urandom();
    seed_plan[3] = $urandom();
    seed_plan[4] = SEED_AT_RESET;

    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_tlast    <= 1'b0;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Seed must come up at its reset value.
    check_seed_reg(SEED_AT_RESET);

    // ---- directed transactions, reset seed ----
    // empty string: start and end with no byte
    send_item(make_item(8'hC3, 1'b0, 1'b1, 1'b1, 32'h0));
    // one-byte string in a single transaction, all-ones length and byte
    send_item(make_item(8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    // exactly one word, no tail
    send_item(make_item(8'h00, 1'b1, 1'b1, 1'b0, 32'd4));
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_item(make_item(8'h80, 1'b1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(8'h01, 1'b1, 1'b0, 1'b1, 32'h5555_5555));
    // three-byte tail only
    send_item(make_item(8'hA5, 1'b1, 1'b1, 1'b0, 32'd3));
    send_item(make_item(8'h5A, 1'b1, 1'b0, 1'b0, 32'hAAAA_AAAA));
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b1, 32'h0));
    // bytes with no start continue from the cleared state; end rides alone
    send_item(make_item(8'h12, 1'b1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(8'h34, 1'b1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(8'h00, 1'b0, 1'b0, 1'b1, 32'h0));
    // end with no start and nothing pending
    send_item(make_item(8'h77, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    // restart mid-string, lengths disagreeing with the bytes sent
    send_item(make_item(8'h11, 1'b1, 1'b1, 1'b0, 32'h8000_0000));
    send_item(make_item(8'h22, 1'b1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(8'h33, 1'b1, 1'b1, 1'b0, 32'd1));
    send_item(make_item(8'h44, 1'b1, 1'b0, 1'b1, 32'h0));
    // transaction with no byte and no marks changes nothing
    send_item(make_item(8'hEE, 1'b0, 1'b0, 1'b0, 32'hDEAD_BEEF));
    // five bytes: one word plus a one-byte tail
    for (i = 0; i < 5; i++)
      send_item(make_item(8'(8'h61 + i), 1'b1, i == 0, i == 4, (i == 0) ? 32'd5 : 32'h0));
    close_phase();

    // ---- random phases, one per seed setting ----
    for (p = 0; p < 5; p++) begin
      cfg_access(APB_WRITE, SEED_ADDR, seed_plan[p], rd);
      scb.seed = seed_plan[p];
      check_seed_reg(seed_plan[p]);
      if (p == 0) begin
        // Receiver holds off while one-byte strings go in back to back, so the
        // command queue fills and in_tready drops; then the sender waits for
        // every pending hash.
        rx_hold   = LONG_HOLD;
        tx_no_gap = 1'b1;
        for (i = 0; i < 40; i++)
          send_item(make_item(8'($urandom()), 1'b1, 1'b1, 1'b1, $urandom_range(0, 3)));
        tx_no_gap = 1'b0;
        stop_input();
        wait_drained();
      end
      run_random(PHASE_ITEMS);
      close_phase();
    end

    $display("Covered %0d string transactions and %0d hash results", items_sent,
             scb.hashes_checked);
    $display("over the reset seed and five written seeds, all-zero and all-one among them.");
    if (scb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mh2_pkg.sv
hdl/mh2_front.sv
hdl/mh2_cmdq.sv
hdl/mh2_back.sv
hdl/murmur2_string_hash_top.sv
dv/murmur2_string_hash_top_tb.sv
